// ===== src/mhp_pkg.sv =====
// Shared types, phase codes and field-size helpers for the message header parser.
// Used by mhp_fsm, mhp_out_reg and message_header_parser; depends on nothing.
`default_nettype none

package mhp_pkg;

    // Header parsing phases.
    localparam logic [1:0] PH_FLAGS = 2'd0;
    localparam logic [1:0] PH_TYPE  = 2'd1;
    localparam logic [1:0] PH_LINK  = 2'd2;
    localparam logic [1:0] PH_LEN   = 2'd3;

    // Mask for one 2-bit size code.
    localparam logic [1:0] CODE_MASK = 2'h3;

    // Width of the packed output tdata: 100 payload bits rounded up to bytes.
    localparam int unsigned RESULT_BITS = 32 + 32 + 32 + 4;
    localparam int unsigned M_TDATA_W   = ((RESULT_BITS + 7) / 8) * 8;

    // One decoded header.
    typedef struct packed {
        logic [3:0]  header_length;
        logic [31:0] body_length;
        logic [31:0] link_id;
        logic [31:0] msg_type;
    } t_result;

    // Type field size in bytes: 1, 2, 3 or 4.
    function automatic logic [2:0] type_bytes(input logic [1:0] code);
        type_bytes = {1'b0, code & CODE_MASK} + 3'd1;
    endfunction

    // Link id or body length size in bytes: 0, 1, 2 or 4.
    function automatic logic [2:0] opt_bytes(input logic [1:0] code);
        opt_bytes = ((code & CODE_MASK) == 2'd3) ? 3'd4 : {1'b0, code & CODE_MASK};
    endfunction

endpackage

`default_nettype wire

// ===== src/mhp_fsm.sv =====
// Header phase tracking and field accumulation, one byte per accepted item.
// Depends on mhp_pkg for phase codes, the result struct and size helpers.
`default_nettype none

module mhp_fsm (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_byte,
    output logic                  o_completes,
    output mhp_pkg::t_result      o_result
);
    import mhp_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic [5:0]  r_codes, n_codes;
    logic [1:0]  r_index, n_index;
    logic [31:0] r_type, n_type;
    logic [31:0] r_link, n_link;
    logic [31:0] r_len,  n_len;

    logic [2:0]  w_field_bytes;
    logic        w_field_done;
    logic        w_link_used;
    logic        w_len_used;
    logic [31:0] w_lane;

    // Size of the field being collected and whether this byte ends it.
    always_comb begin
        case (r_phase)
            PH_TYPE: w_field_bytes = type_bytes(r_codes[1:0]);
            PH_LINK: w_field_bytes = opt_bytes(r_codes[3:2]);
            PH_LEN:  w_field_bytes = opt_bytes(r_codes[5:4]);
            default: w_field_bytes = 3'd0;
        endcase
    end

    assign w_field_done = (({1'b0, r_index} + 3'd1) >= w_field_bytes);
    assign w_link_used  = (r_codes[3:2] != 2'd0);
    assign w_len_used   = (r_codes[5:4] != 2'd0);

    // The byte positioned in its lane of the 32-bit field.
    assign w_lane = {24'd0, i_byte} << {r_index, 3'b000};

    // A header completes on the last byte of its last non-empty field.
    always_comb begin
        o_completes = 1'b0;
        if (w_field_done) begin
            case (r_phase)
                PH_TYPE: o_completes = !w_link_used && !w_len_used;
                PH_LINK: o_completes = !w_len_used;
                PH_LEN:  o_completes = 1'b1;
                default: o_completes = 1'b0;
            endcase
        end
    end

    // Next-state logic for phase, index and accumulators.
    always_comb begin
        n_phase = r_phase;
        n_codes = r_codes;
        n_index = r_index;
        n_type  = r_type;
        n_link  = r_link;
        n_len   = r_len;
        if (i_accept) begin
            if (r_phase == PH_FLAGS) begin
                n_codes = i_byte[5:0];
                n_index = 2'd0;
                n_type  = 32'd0;
                n_link  = 32'd0;
                n_len   = 32'd0;
                n_phase = PH_TYPE;
            end else begin
                case (r_phase)
                    PH_TYPE: n_type = r_type | w_lane;
                    PH_LINK: n_link = r_link | w_lane;
                    default: n_len  = r_len  | w_lane;
                endcase
                if (!w_field_done) begin
                    n_index = r_index + 2'd1;
                end else begin
                    n_index = 2'd0;
                    if (o_completes) begin
                        n_phase = PH_FLAGS;
                    end else if (r_phase == PH_TYPE && w_link_used) begin
                        n_phase = PH_LINK;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
            end
        end
    end

    // Result fields include the byte being accepted now.
    always_comb begin
        o_result.msg_type      = n_type;
        o_result.link_id       = n_link;
        o_result.body_length   = n_len;
        o_result.header_length = 4'd1 + {1'b0, type_bytes(r_codes[1:0])}
                               + {1'b0, opt_bytes(r_codes[3:2])}
                               + {1'b0, opt_bytes(r_codes[5:4])};
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAGS;
            r_codes <= 6'd0;
            r_index <= 2'd0;
            r_type  <= 32'd0;
            r_link  <= 32'd0;
            r_len   <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_codes <= n_codes;
            r_index <= n_index;
            r_type  <= n_type;
            r_link  <= n_link;
            r_len   <= n_len;
        end
    end

    // The byte index only moves inside a field.
    a_index_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FLAGS |-> r_index == 2'd0)
        else $error("byte index not zero while waiting for flags");

    // A flags byte never finishes a header.
    a_no_flag_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FLAGS |-> !o_completes)
        else $error("header completed on a flags byte");

    // A completed header returns to the flags phase.
    a_back_to_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_completes |=> r_phase == PH_FLAGS)
        else $error("phase did not return to flags after a result");

endmodule

`default_nettype wire

// ===== src/mhp_out_reg.sv =====
// Output result register with valid flag for the master-side stream.
// Depends on mhp_pkg for the result struct.
`default_nettype none

module mhp_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire mhp_pkg::t_result i_result,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output mhp_pkg::t_result      o_result
);
    import mhp_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Valid flag: set on load, cleared when the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_valid || i_ready)
        else $error("result register overwritten while stalled");

    // A loaded result is presented on the next cycle.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded result not marked valid");

    // A waiting result is not dropped.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid)
        else $error("stalled result dropped");

endmodule

`default_nettype wire

// ===== src/message_header_parser.sv =====
// Top level of the message header parser: byte stream in, decoded header out.
// Depends on mhp_pkg, mhp_fsm and mhp_out_reg.
//
//  Channel   Dir  Payload (tdata, low bit up)
//  s (in)    in   [7:0] byte_in
//  m (out)   out  [31:0] msg_type, [63:32] link_id, [95:64] body_length,
//                 [99:96] header_length, [103:100] zero
//
// A result appears in the output register in the cycle after the last header byte
// is accepted. Reset is synchronous, active low, and returns the parser to waiting
// for a flags byte with no result pending. One byte is accepted per cycle, even
// while a result waits, except that a header's last byte waits only while the
// output register holds an untaken result.
`default_nettype none

module message_header_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [7:0]                    i_s_tdata,   // [7:0] byte_in
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [31:0] msg_type, [63:32] link_id, [95:64] body_length, [99:96] header_length
    output logic [mhp_pkg::M_TDATA_W-1:0]      o_m_tdata
);
    import mhp_pkg::*;

    logic    w_accept;
    logic    w_completes;
    t_result w_result;
    t_result w_out;

    // Only a completing byte needs room in the output register.
    assign o_s_tready = !w_completes || !o_m_tvalid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    mhp_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_s_tdata),
        .o_completes (w_completes),
        .o_result    (w_result)
    );

    mhp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept && w_completes),
        .i_result (w_result),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_result (w_out)
    );

    // Pack the result fields, zero padded to whole bytes.
    assign o_m_tdata = {{(M_TDATA_W - RESULT_BITS){1'b0}}, w_out};

endmodule

`default_nettype wire
